FILE: rtl/cicd_pkg.sv
// Shared constants, types and helper functions for the cloud-in-cell deposit unit.
// Used by every module in this folder; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package cicd_pkg;

  localparam int LAYERS  = 4;
  localparam int ROWS    = 64;
  localparam int COLUMNS = 64;
  localparam int SPECIES = 4;

  localparam int CELLS   = LAYERS * ROWS * COLUMNS;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int SUM_W   = 48;
  localparam int VAL_W   = 33;
  localparam int DELTA_W = 35;
  localparam int NVALS   = 5;
  localparam int SLOTS   = 4 + SPECIES;

  // Slot positions inside one grid row.
  localparam int SLOT_JX  = 0;
  localparam int SLOT_JY  = 1;
  localparam int SLOT_JZ  = 2;
  localparam int SLOT_RHO = 3;
  localparam int SLOT_SPC = 4;

  // Operation codes.
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic [SLOTS-1:0][SUM_W-1:0] row_t;
  typedef logic [NVALS-1:0][VAL_W-1:0] vals_t;

  // Clamp a Q1.16 fraction to one.
  function automatic logic [16:0] clamp_frac(input logic [16:0] f);
    return (f > ONE_Q16) ? ONE_Q16 : f;
  endfunction

  // Product of two Q1.16 weights, rounded half up.
  function automatic logic [16:0] wmul(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] p;
    p = 35'(a) * 35'(b) + 35'd32768;
    return p[32:16];
  endfunction

  // Linear cell index of a corner that is known to be inside the grid.
  function automatic logic [CELL_W-1:0] cell_idx(input logic [2:0] l, input logic [6:0] r,
                                                 input logic [6:0] c);
    int unsigned idx;
    idx = (int'(l) * ROWS + int'(r)) * COLUMNS + int'(c);
    return idx[CELL_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cicd_grid_mem.sv
// Grid store: one row per cell holding current, charge and species density sums.
// Single write port and one registered read port; uses cicd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cicd_grid_mem (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [cicd_pkg::CELL_W-1:0]  waddr,
  input  wire  cicd_pkg::row_t         wdata,
  input  wire                          re,
  input  wire  [cicd_pkg::CELL_W-1:0]  raddr,
  output cicd_pkg::row_t               rdata_r
);

  cicd_pkg::row_t mem [cicd_pkg::CELLS];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cicd_upd.sv
// Update datapath: scales the five contributions by a corner weight into registered
// deltas, then adds them with saturation onto a grid row. Uses cicd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cicd_upd (
  input  wire                  clk,
  input  wire                  load,
  input  wire  cicd_pkg::vals_t vals,
  input  wire  [16:0]          weight,
  input  wire  [1:0]           species,
  input  wire  cicd_pkg::row_t row_i,
  output cicd_pkg::row_t       row_o
);

  logic signed [cicd_pkg::DELTA_W-1:0] delta_r [cicd_pkg::NVALS];
  logic signed [cicd_pkg::DELTA_W-1:0] delta_nxt [cicd_pkg::NVALS];

  // Saturating add of a delta onto a 48-bit sum.
  function automatic logic [cicd_pkg::SUM_W-1:0] sat_add(
      input logic [cicd_pkg::SUM_W-1:0] s, input logic signed [cicd_pkg::DELTA_W-1:0] d);
    logic signed [cicd_pkg::SUM_W:0] t;
    t = $signed({s[cicd_pkg::SUM_W-1], s}) + (cicd_pkg::SUM_W+1)'(d);
    if (t[cicd_pkg::SUM_W] != t[cicd_pkg::SUM_W-1]) begin
      return t[cicd_pkg::SUM_W] ? cicd_pkg::SUM_MIN : cicd_pkg::SUM_MAX;
    end
    return t[cicd_pkg::SUM_W-1:0];
  endfunction

  // Scale each contribution: round(v * w / 2^16), ties toward plus infinity.
  always_comb begin
    logic signed [50:0] p;
    for (int i = 0; i < cicd_pkg::NVALS; i++) begin
      p = 51'($signed(vals[i])) * 51'($signed({1'b0, weight}));
      p = (p + 51'sd32768) >>> 16;
      delta_nxt[i] = p[cicd_pkg::DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < cicd_pkg::NVALS; i++) begin
        delta_r[i] <= delta_nxt[i];
      end
    end
  end

  // Accumulate onto the row read from the store; only the item's species slot moves.
  always_comb begin
    row_o = row_i;
    row_o[cicd_pkg::SLOT_JX]  = sat_add(row_i[cicd_pkg::SLOT_JX],  delta_r[0]);
    row_o[cicd_pkg::SLOT_JY]  = sat_add(row_i[cicd_pkg::SLOT_JY],  delta_r[1]);
    row_o[cicd_pkg::SLOT_JZ]  = sat_add(row_i[cicd_pkg::SLOT_JZ],  delta_r[2]);
    row_o[cicd_pkg::SLOT_RHO] = sat_add(row_i[cicd_pkg::SLOT_RHO], delta_r[3]);
    for (int s = 0; s < cicd_pkg::SPECIES; s++) begin
      if (32'(species) == s) begin
        row_o[cicd_pkg::SLOT_SPC + s] = sat_add(row_i[cicd_pkg::SLOT_SPC + s], delta_r[4]);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cic_current_density_deposit_unit.sv
// Cloud-in-cell deposit unit: control sequencer, input capture and result register.
// Instantiates cicd_grid_mem and cicd_upd; uses cicd_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one beat per item: a deposit
//   (operation 0) or a read (operation 1). A deposit visits its eight corners in
//   turn, each through S_W1, S_W2, S_MUL and S_WR (two weight multiplies, store read,
//   scale, write back), and gives no result. Corners outside the grid take their
//   slot but write nothing. A read passes through S_RD, the store read, and S_RDO,
//   which loads the result register; its result beat is then offered on the output
//   channel. The unit takes the next beat only in idle, once it is through with the
//   previous item; the corner sequencer and the single store port set the pace.
//   The result register parts the two sides: a new item is accepted while an
//   earlier result waits. A stalled receiver only blocks a read that must load
//   the result register while it is still full.
//   After reset the store is cleared one cell per cycle, with in_ready low. The cfg
//   channel writes active_layer at any time it is offered (cfg_ready is always high);
//   the user must change it only while the unit is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module cic_current_density_deposit_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_active_layer,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_operation,
  input  wire  [5:0]  in_row,
  input  wire  [5:0]  in_column,
  input  wire  [16:0] in_frac_x,
  input  wire  [16:0] in_frac_y,
  input  wire  [16:0] in_frac_z,
  input  wire  [31:0] in_current_x,
  input  wire  [31:0] in_current_y,
  input  wire  [31:0] in_current_z,
  input  wire  [31:0] in_charge,
  input  wire  [31:0] in_particle_weight,
  input  wire  [1:0]  in_species,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [47:0] out_sum_current_x,
  output logic [47:0] out_sum_current_y,
  output logic [47:0] out_sum_current_z,
  output logic [47:0] out_sum_charge,
  output logic [47:0] out_sum_species_density
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_W1   = 3'd2;
  localparam logic [2:0] S_W2   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;
  localparam logic [2:0] S_RDO  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [cicd_pkg::CELL_W-1:0] clr_r, clr_nxt;
  logic [2:0]                  corner_r, corner_nxt;
  logic [1:0]                  layer_r;

  // Captured item.
  logic                        op_r;
  logic [5:0]                  row_r, col_r;
  logic [16:0]                 fx_r, fy_r, fz_r;
  cicd_pkg::vals_t             vals_r;
  logic [1:0]                  spc_r;

  // Per-corner working registers.
  logic [16:0]                 wyz_r, w_r;
  logic                        ok_r;
  logic [cicd_pkg::CELL_W-1:0] addr_r;

  // Result register.
  logic                        out_valid_r;
  logic [47:0]                 res_r [cicd_pkg::NVALS];

  logic                        in_acc;
  logic                        out_load;
  logic [2:0]                  cl;
  logic [6:0]                  cr, cc;
  logic [16:0]                 wx, wy, wz;
  logic                        read_ok;
  logic [47:0]                 dens_sel;

  logic                        mem_we, mem_re;
  logic [cicd_pkg::CELL_W-1:0] mem_waddr, mem_raddr;
  cicd_pkg::row_t              mem_wdata, mem_rdata, upd_row;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_RDO) && (!out_valid_r || out_ready);

  assign out_sum_current_x       = res_r[0];
  assign out_sum_current_y       = res_r[1];
  assign out_sum_current_z       = res_r[2];
  assign out_sum_charge          = res_r[3];
  assign out_sum_species_density = res_r[4];

  // Corner coordinates and axis weights for the current corner.
  always_comb begin
    cl = {1'b0, layer_r} + {2'b0, corner_r[2]};
    cr = {1'b0, row_r} + {6'b0, corner_r[1]};
    cc = {1'b0, col_r} + {6'b0, corner_r[0]};
    wx = corner_r[2] ? fx_r : cicd_pkg::ONE_Q16 - fx_r;
    wy = corner_r[1] ? fy_r : cicd_pkg::ONE_Q16 - fy_r;
    wz = corner_r[0] ? fz_r : cicd_pkg::ONE_Q16 - fz_r;
    read_ok = (32'(layer_r) < cicd_pkg::LAYERS) && (32'(row_r) < cicd_pkg::ROWS) &&
              (32'(col_r) < cicd_pkg::COLUMNS);
    dens_sel = '0;
    for (int s = 0; s < cicd_pkg::SPECIES; s++) begin
      if (32'(spc_r) == s) begin
        dens_sel = mem_rdata[cicd_pkg::SLOT_SPC + s];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    corner_nxt = corner_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == cicd_pkg::CELLS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt  = (in_operation == cicd_pkg::OP_READ) ? S_RD : S_W1;
          corner_nxt = 3'd0;
        end
      end
      S_W1:  state_nxt = S_W2;
      S_W2:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_WR;
      S_WR: begin
        corner_nxt = corner_r + 1'b1;
        state_nxt  = (corner_r == 3'd7) ? S_IDLE : S_W1;
      end
      S_RD:  state_nxt = S_RDO;
      S_RDO: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Store port control.
  always_comb begin
    mem_we    = (state_r == S_CLR) || ((state_r == S_WR) && ok_r);
    mem_waddr = (state_r == S_CLR) ? clr_r : addr_r;
    mem_wdata = (state_r == S_CLR) ? '0 : upd_row;
    mem_re    = (state_r == S_W2) || (state_r == S_RD);
    mem_raddr = (state_r == S_RD) ? cicd_pkg::cell_idx({1'b0, layer_r}, {1'b0, row_r},
                                                       {1'b0, col_r}) : addr_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      corner_r    <= 3'd0;
      layer_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      corner_r <= corner_nxt;
      if (cfg_valid && cfg_ready) begin
        layer_r <= cfg_active_layer;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, corner weights and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_operation;
      row_r     <= in_row;
      col_r     <= in_column;
      fx_r      <= cicd_pkg::clamp_frac(in_frac_x);
      fy_r      <= cicd_pkg::clamp_frac(in_frac_y);
      fz_r      <= cicd_pkg::clamp_frac(in_frac_z);
      vals_r[0] <= {in_current_x[31], in_current_x};
      vals_r[1] <= {in_current_y[31], in_current_y};
      vals_r[2] <= {in_current_z[31], in_current_z};
      vals_r[3] <= {in_charge[31], in_charge};
      vals_r[4] <= {1'b0, in_particle_weight};
      spc_r     <= in_species;
    end
    if (state_r == S_W1) begin
      wyz_r  <= cicd_pkg::wmul(wy, wz);
      ok_r   <= (32'(cl) < cicd_pkg::LAYERS) && (32'(cr) < cicd_pkg::ROWS) &&
                (32'(cc) < cicd_pkg::COLUMNS);
      addr_r <= cicd_pkg::cell_idx(cl, cr, cc);
    end
    if (state_r == S_W2) begin
      w_r <= cicd_pkg::wmul(wx, wyz_r);
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        res_r[i] <= read_ok ? mem_rdata[i] : '0;
      end
      res_r[4] <= read_ok ? dens_sel : '0;
    end
  end

  cicd_grid_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  cicd_upd u_upd (
    .clk     (clk),
    .load    (state_r == S_MUL),
    .vals    (vals_r),
    .weight  (w_r),
    .species (spc_r),
    .row_i   (mem_rdata),
    .row_o   (upd_row)
  );

  // The store is written only by the clearing sweep or a corner write-back.
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR || (state_r == S_WR && op_r == cicd_pkg::OP_DEPOSIT)))
    else $error("store write outside clear or write-back");

  // A read item goes straight to the store read.
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == cicd_pkg::OP_READ) |=> state_r == S_RD)
    else $error("read item did not start a store read");

  // The corner counter is back at zero whenever the unit is idle.
  a_corner_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (corner_r == 3'd0))
    else $error("corner counter not wrapped at idle");

  // A result is loaded only when the register is free or being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r[0])))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

FILE: tb/sv/cic_current_density_deposit_unit_tb.sv
// Testbench for the cloud-in-cell deposit unit: random and directed deposit and read beats,
// checked against a trilinear deposition predictor kept inside this file.
// Depends on cicd_pkg and cic_current_density_deposit_unit.
`timescale 1ns / 1ps
module cic_current_density_deposit_unit_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 60000;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef enum {K_ITEM, K_CFG, K_DRAIN, K_MODE} kind_t;

  typedef struct {
    kind_t       kind;
    logic        op;
    logic [5:0]  row, col;
    logic [16:0] fx, fy, fz;
    logic [31:0] jx, jy, jz, rho, pw;
    logic [1:0]  spc;
    int          a, b;
  } beat_t;

  typedef struct {
    logic [47:0] jx, jy, jz, rho, dens;
  } cell_sums_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_active_layer = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = cicd_pkg::OP_DEPOSIT;
  logic [5:0] in_row = '0, in_column = '0;
  logic [16:0] in_frac_x = '0, in_frac_y = '0, in_frac_z = '0;
  logic [31:0] in_current_x = '0, in_current_y = '0, in_current_z = '0;
  logic [31:0] in_charge = '0, in_particle_weight = '0;
  logic [1:0] in_species = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [47:0] out_sum_current_x, out_sum_current_y, out_sum_current_z;
  logic [47:0] out_sum_charge, out_sum_species_density;

  cic_current_density_deposit_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_active_layer(cfg_active_layer),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_row(in_row), .in_column(in_column),
    .in_frac_x(in_frac_x), .in_frac_y(in_frac_y), .in_frac_z(in_frac_z),
    .in_current_x(in_current_x), .in_current_y(in_current_y),
    .in_current_z(in_current_z), .in_charge(in_charge),
    .in_particle_weight(in_particle_weight), .in_species(in_species),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sum_current_x(out_sum_current_x), .out_sum_current_y(out_sum_current_y),
    .out_sum_current_z(out_sum_current_z), .out_sum_charge(out_sum_charge),
    .out_sum_species_density(out_sum_species_density)
  );

  // Clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the grid store and the layer register.
  longint jx_grid[cicd_pkg::CELLS];
  longint jy_grid[cicd_pkg::CELLS];
  longint jz_grid[cicd_pkg::CELLS];
  longint rho_grid[cicd_pkg::CELLS];
  longint dens_grid[cicd_pkg::CELLS*cicd_pkg::SPECIES];
  int     shadow_layer = 0;

  beat_t      pending_beats[$];
  cell_sums_t expected_sums[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0, deposits = 0, reads = 0, results = 0, cfg_writes = 0;
  int quiet_cycles = 0;

  function automatic longint weigh(longint v, longint w);
    return (v * w + 32768) >>> 16;
  endfunction

  function automatic longint sat_add(longint s, longint d);
    longint r;
    r = s + d;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r;
  endfunction

  function automatic longint clamp_q16(logic [16:0] f);
    return (f > 17'd65536) ? 65536 : longint'(f);
  endfunction

  // Spread one particle over the eight corners of its cell.
  function automatic void deposit_particle();
    longint wx[2], wy[2], wz[2];
    longint vjx, vjy, vjz, vrho, vpw, wyz, w;
    int l, r, c, cell_ix;
    wx[1] = clamp_q16(in_frac_x); wx[0] = 65536 - wx[1];
    wy[1] = clamp_q16(in_frac_y); wy[0] = 65536 - wy[1];
    wz[1] = clamp_q16(in_frac_z); wz[0] = 65536 - wz[1];
    vjx = longint'($signed(in_current_x));
    vjy = longint'($signed(in_current_y));
    vjz = longint'($signed(in_current_z));
    vrho = longint'($signed(in_charge));
    vpw = longint'({32'b0, in_particle_weight});
    for (int dl = 0; dl < 2; dl++)
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++) begin
          l = shadow_layer + dl;
          r = int'(in_row) + dr;
          c = int'(in_column) + dc;
          // Corners past the grid edge are dropped.
          if (l >= cicd_pkg::LAYERS || r >= cicd_pkg::ROWS || c >= cicd_pkg::COLUMNS)
            continue;
          wyz = (wy[dr] * wz[dc] + 32768) >> 16;
          w = (wx[dl] * wyz + 32768) >> 16;
          cell_ix = (l * cicd_pkg::ROWS + r) * cicd_pkg::COLUMNS + c;
          jx_grid[cell_ix] = sat_add(jx_grid[cell_ix], weigh(vjx, w));
          jy_grid[cell_ix] = sat_add(jy_grid[cell_ix], weigh(vjy, w));
          jz_grid[cell_ix] = sat_add(jz_grid[cell_ix], weigh(vjz, w));
          rho_grid[cell_ix] = sat_add(rho_grid[cell_ix], weigh(vrho, w));
          if (int'(in_species) < cicd_pkg::SPECIES)
            dens_grid[cell_ix*cicd_pkg::SPECIES + in_species] =
              sat_add(dens_grid[cell_ix*cicd_pkg::SPECIES + in_species], weigh(vpw, w));
        end
  endfunction

  // Sums of one cell in the active layer.
  function automatic cell_sums_t read_cell();
    cell_sums_t s;
    int cell_ix;
    s = '{default: '0};
    if (shadow_layer < cicd_pkg::LAYERS) begin
      cell_ix = (shadow_layer * cicd_pkg::ROWS + int'(in_row)) * cicd_pkg::COLUMNS +
                int'(in_column);
      s.jx = jx_grid[cell_ix][47:0];
      s.jy = jy_grid[cell_ix][47:0];
      s.jz = jz_grid[cell_ix][47:0];
      s.rho = rho_grid[cell_ix][47:0];
      if (int'(in_species) < cicd_pkg::SPECIES)
        s.dens = dens_grid[cell_ix*cicd_pkg::SPECIES + in_species][47:0];
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic report_fault(string what);
    $display("MISMATCH: %s at %0t", what, $realtime);
    errors++;
  endtask

  // Driver: input and configuration channels, fed from the pending beat queue.
  always @(posedge clk) begin
    beat_t b;
    logic next_valid;
    next_valid = in_valid;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        shadow_layer = int'(cfg_active_layer);
        cfg_writes++;
        cfg_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (in_operation == cicd_pkg::OP_READ) begin
          expected_sums.push_back(read_cell());
          reads++;
        end else begin
          deposit_particle();
          deposits++;
        end
        next_valid = 1'b0;
      end
      if (!next_valid && !cfg_valid) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats[0];
          case (b.kind)
            K_ITEM: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                void'(pending_beats.pop_front());
                next_valid = 1'b1;
                in_operation <= b.op;
                in_row <= b.row;
                in_column <= b.col;
                in_frac_x <= b.fx;
                in_frac_y <= b.fy;
                in_frac_z <= b.fz;
                in_current_x <= b.jx;
                in_current_y <= b.jy;
                in_current_z <= b.jz;
                in_charge <= b.rho;
                in_particle_weight <= b.pw;
                in_species <= b.spc;
              end
            end
            K_CFG: begin
              void'(pending_beats.pop_front());
              cfg_valid <= 1'b1;
              cfg_active_layer <= b.a[1:0];
            end
            K_DRAIN: begin
              // Hold off until every read result is back, then let a deposit finish.
              if (expected_sums.size() == 0) begin
                void'(pending_beats.pop_front());
                hold_cycles = SETTLE_CYCLES;
              end
            end
            default: begin
              void'(pending_beats.pop_front());
              send_idle_pct = b.a;
              recv_idle_pct = b.b;
            end
          endcase
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: result channel backpressure and checking.
  always @(posedge clk) begin
    cell_sums_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results++;
        if (expected_sums.size() == 0) begin
          report_fault("result beat with nothing expected");
        end else begin
          e = expected_sums.pop_front();
          if (out_sum_current_x !== e.jx) report_mismatch("sum_current_x", out_sum_current_x, e.jx);
          if (out_sum_current_y !== e.jy) report_mismatch("sum_current_y", out_sum_current_y, e.jy);
          if (out_sum_current_z !== e.jz) report_mismatch("sum_current_z", out_sum_current_z, e.jz);
          if (out_sum_charge !== e.rho) report_mismatch("sum_charge", out_sum_charge, e.rho);
          if (out_sum_species_density !== e.dens)
            report_mismatch("sum_species_density", out_sum_species_density, e.dens);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void add_item(logic op, int row, int col, int fx, int fy, int fz,
                                   logic [31:0] jx, logic [31:0] jy, logic [31:0] jz,
                                   logic [31:0] rho, logic [31:0] pw, int spc);
    beat_t b;
    b = '{kind: K_ITEM, op: op, row: 6'(row), col: 6'(col),
          fx: 17'(fx), fy: 17'(fy), fz: 17'(fz),
          jx: jx, jy: jy, jz: jz, rho: rho, pw: pw, spc: 2'(spc), a: 0, b: 0};
    pending_beats.push_back(b);
  endfunction

  function automatic void add_ctrl(kind_t k, int a, int b);
    beat_t x;
    x = '{kind: k, default: '0};
    x.a = a;
    x.b = b;
    pending_beats.push_back(x);
  endfunction

  // Layer changes only once the unit is quiet.
  function automatic void set_layer(int layer);
    add_ctrl(K_DRAIN, 0, 0);
    add_ctrl(K_CFG, layer, 0);
  endfunction

  function automatic int rand_frac();
    case ($urandom_range(5))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(131071, 65537);
      default: return $urandom_range(65536);
    endcase
  endfunction

  // Positions cluster in a few corners so reads find deposited sums.
  function automatic int rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(63);
      1: return $urandom_range(63, 61);
      default: return $urandom_range(3);
    endcase
  endfunction

  function automatic void add_random_item();
    logic op;
    op = ($urandom_range(99) < 35) ? cicd_pkg::OP_READ : cicd_pkg::OP_DEPOSIT;
    add_item(op, rand_pos(), rand_pos(), rand_frac(), rand_frac(), rand_frac(),
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(3));
  endfunction

  initial begin
    // Directed beats: edges of the grid, extreme fractions and values, every species.
    set_layer(0);
    add_item(cicd_pkg::OP_DEPOSIT, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    add_item(cicd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(cicd_pkg::OP_DEPOSIT, 63, 63, 65536, 65536, 65536, 32'h8000_0000,
             32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 3);
    add_item(cicd_pkg::OP_DEPOSIT, 62, 62, 131071, 98304, 32768, 32'h1234_5678,
             32'hFEDC_BA98, 32'h0000_8000, 32'hFFFF_8000, 32'h8000_0001, 1);
    add_item(cicd_pkg::OP_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 3);
    add_item(cicd_pkg::OP_READ, 62, 62, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_item(cicd_pkg::OP_READ, 63, 62, 131071, 131071, 131071, '1, '1, '1, '1, '1, 2);
    add_item(cicd_pkg::OP_DEPOSIT, 10, 20, 1, 65535, 32767, 32'd3, -32'sd3, 32'd2,
             -32'sd1, 32'd7, 2);
    add_item(cicd_pkg::OP_READ, 10, 21, 0, 0, 0, 0, 0, 0, 0, 0, 2);
    add_item(cicd_pkg::OP_READ, 11, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    set_layer(3);
    add_item(cicd_pkg::OP_DEPOSIT, 5, 5, 32768, 32768, 32768, 32'h0100_0000,
             32'h0200_0000, 32'h0300_0000, 32'h0400_0000, 32'h0500_0000, 1);
    add_item(cicd_pkg::OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_item(cicd_pkg::OP_READ, 6, 6, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    set_layer(2);
    add_item(cicd_pkg::OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    // Random phases: receiver idle heavy, then sender idle heavy, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      set_layer(phase == 0 ? 1 : (phase == 1 ? 2 : 0));
      add_ctrl(K_MODE, phase == 0 ? 22 : (phase == 1 ? 67 : 0),
               phase == 0 ? 67 : (phase == 1 ? 22 : 0));
      for (int i = 0; i < 265; i++) begin
        add_random_item();
        if (i == 130) add_ctrl(K_DRAIN, 0, 0);
      end
    end
    set_layer(3);
    for (int i = 0; i < 20; i++) add_random_item();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || cfg_valid || hold_cycles > 0 ||
           expected_sums.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_sums.size() > 0) begin
      report_fault($sformatf("%0d read results never arrived", expected_sums.size()));
    end
    $display("Ran %0d deposits and %0d reads over %0d layer writes; %0d results checked.",
             deposits, reads, cfg_writes, results);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
